FILE: hdl/chunk_rms_peak_meter_core_assert.svh
// Assertion macros used by the meter core RTL file.
`ifndef CHUNK_RMS_PEAK_METER_CORE_ASSERT_SVH
`define CHUNK_RMS_PEAK_METER_CORE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define CRPM_ASSERT_HOLDS(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("crpm: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define CRPM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("crpm: next-cycle check failed");

`endif

FILE: hdl/crpm_pkg.sv
package crpm_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 16;

    // Radicand width and digit steps of the root (two radicand bits per step)
    localparam int RAD_W      = 32;
    localparam int ROOT_STEPS = RAD_W / 2;
    // Partial remainder width of the root: two shifted-in bits over a 16-bit remainder
    localparam int ROOT_REM_W = LEVEL_W + 2;

    localparam int MAX_CHUNK_SAMPLES_DEF = 4096;

    // Commands from the accumulator to the mean/root unit
    typedef struct packed {
        logic start;
        logic ack;
    } crpm_ctrl_t;

    // Status of the mean/root unit
    typedef struct packed {
        logic busy;
        logic done;
    } crpm_stat_t;

endpackage

FILE: hdl/crpm_mean_root.sv
module crpm_mean_root #(
    parameter int SUM_W = 43,
    parameter int CNT_W = 13
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  crpm_pkg::crpm_ctrl_t        ctrl,
    input  logic [SUM_W-1:0]            sum_in,
    input  logic [CNT_W-1:0]            count_in,
    output crpm_pkg::crpm_stat_t        stat,
    output logic [crpm_pkg::LEVEL_W-1:0] root_out
);
    import crpm_pkg::*;

    localparam int SUB_W  = (CNT_W + 1 > ROOT_REM_W) ? CNT_W + 1 : ROOT_REM_W;
    localparam int STEP_W = $clog2(SUM_W);

    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_DIV  = 2'd1;
    localparam logic [1:0] U_ROOT = 2'd2;
    localparam logic [1:0] U_DONE = 2'd3;

    logic [1:0]         ustate_reg, ustate_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [SUB_W-1:0]   rem_reg, rem_next;
    logic [SUM_W-1:0]   dvd_reg, dvd_next;
    logic [CNT_W-1:0]   div_reg, div_next;
    logic [RAD_W-1:0]   rad_reg, rad_next;
    logic [LEVEL_W-1:0] root_reg, root_next;

    logic [SUB_W-1:0]   op_a;
    logic [SUB_W-1:0]   op_b;
    logic [SUB_W-1:0]   diff;
    logic               borrow;
    logic               fits;

    // Shared compare-subtract: divide step or root digit step
    always_comb begin
        if (ustate_reg == U_ROOT) begin
            op_a = SUB_W'({rem_reg[LEVEL_W-1:0], rad_reg[RAD_W-1 -: 2]});
            op_b = SUB_W'({root_reg, 2'b01});
        end else begin
            op_a = SUB_W'({rem_reg[CNT_W-1:0], dvd_reg[SUM_W-1]});
            op_b = SUB_W'(div_reg);
        end
        {borrow, diff} = {1'b0, op_a} - {1'b0, op_b};
        fits = !borrow;
    end

    // Sequence the divide, then the root, then hold the result
    always_comb begin
        ustate_next = ustate_reg;
        step_next   = step_reg;
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        div_next    = div_reg;
        rad_next    = rad_reg;
        root_next   = root_reg;
        case (ustate_reg)
            U_IDLE: begin
                if (ctrl.start) begin
                    dvd_next    = sum_in;
                    div_next    = count_in;
                    rem_next    = '0;
                    step_next   = STEP_W'(SUM_W - 1);
                    ustate_next = U_DIV;
                end
            end
            U_DIV: begin
                dvd_next = {dvd_reg[SUM_W-2:0], fits};
                rem_next = fits ? diff : op_a;
                if (step_reg == '0) begin
                    // mean never exceeds 2^30, so the quotient fits the radicand
                    rad_next    = RAD_W'({dvd_reg[SUM_W-2:0], fits});
                    rem_next    = '0;
                    root_next   = '0;
                    step_next   = STEP_W'(ROOT_STEPS - 1);
                    ustate_next = U_ROOT;
                end else begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            U_ROOT: begin
                rad_next  = rad_reg << 2;
                rem_next  = fits ? diff : op_a;
                root_next = {root_reg[LEVEL_W-2:0], fits};
                if (step_reg == '0) begin
                    ustate_next = U_DONE;
                end else begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            U_DONE: begin
                if (ctrl.ack) begin
                    ustate_next = U_IDLE;
                end
            end
            default: begin
                ustate_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ustate_reg <= U_IDLE;
        end else begin
            ustate_reg <= ustate_next;
        end
    end

    // Datapath registers need no reset
    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        div_reg  <= div_next;
        rad_reg  <= rad_next;
        root_reg <= root_next;
    end

    assign stat.busy = (ustate_reg != U_IDLE);
    assign stat.done = (ustate_reg == U_DONE);
    assign root_out  = root_reg;

endmodule

FILE: hdl/chunk_rms_peak_meter_core.sv
// RMS and peak level meter over chunks of signed 16-bit audio samples.
// Input channel s_*: one sample word per handshake, s_last marks the end of a
// chunk. A chunk also closes by itself at MAX_CHUNK_SAMPLES samples.
// Result channel m_*: one word per chunk, m_rms_level is the floor root of the
// floor mean of squares, m_peak_level the largest magnitude (-32768 gives 32768).
// Sequence: a sample that does not close a chunk is captured, then squared and
// accumulated through one 16x16 multiplier. A closing sample holds s_ready
// low through the divide and the root (SUM_W = 43 at the default size):
// SUM_W restoring divide steps at one per cycle, then 16 root digit
// steps, all through one shared compare-subtract unit, then the output load.
// The result sits in an output register, so the block takes the next sample
// while a result waits; if m_ready is still low when the next chunk's result
// is ready, the block holds that result and keeps s_ready low until the
// register frees up.
// Reset clears the running sum, count and peak and drops m_valid; s_ready is
// high in the first cycle after reset.
`include "chunk_rms_peak_meter_core_assert.svh"

module chunk_rms_peak_meter_core #(
    parameter int MAX_CHUNK_SAMPLES = crpm_pkg::MAX_CHUNK_SAMPLES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [crpm_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                s_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [crpm_pkg::LEVEL_W-1:0]        m_rms_level,
    output logic [crpm_pkg::LEVEL_W-1:0]        m_peak_level
);
    import crpm_pkg::*;

    localparam int CNT_W = $clog2(MAX_CHUNK_SAMPLES + 1);
    localparam int SQ_W  = 2 * SAMPLE_W;
    localparam int SUM_W = 2 * (SAMPLE_W - 1) + CNT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ACC  = 2'd1;
    localparam logic [1:0] S_ROOT = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [SAMPLE_W-1:0] mag_reg, mag_next;
    logic                last_reg, last_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [LEVEL_W-1:0]  peak_reg, peak_next;
    logic                m_valid_reg, m_valid_next;
    logic [LEVEL_W-1:0]  rms_out_reg, rms_out_next;
    logic [LEVEL_W-1:0]  peak_out_reg, peak_out_next;

    logic [SAMPLE_W-1:0] raw;
    logic [SAMPLE_W-1:0] mag_in;
    logic [SQ_W-1:0]     square;
    logic [SUM_W-1:0]    sum_acc;
    logic [CNT_W-1:0]    count_acc;
    logic [LEVEL_W-1:0]  peak_acc;
    logic                close;
    logic                out_load;
    crpm_ctrl_t          ctrl;
    crpm_stat_t          stat;
    logic [LEVEL_W-1:0]  root;

    // Magnitude of the incoming word; -32768 maps to 32768
    assign raw    = s_sample;
    assign mag_in = raw[SAMPLE_W-1] ? (SAMPLE_W'(~raw) + SAMPLE_W'(1)) : raw;

    // Square and accumulate the captured magnitude
    assign square    = SQ_W'(mag_reg) * SQ_W'(mag_reg);
    assign sum_acc   = sum_reg + SUM_W'(square);
    assign count_acc = count_reg + CNT_W'(1);
    assign peak_acc  = (mag_reg > peak_reg) ? mag_reg : peak_reg;
    assign close     = last_reg || (count_acc >= CNT_W'(MAX_CHUNK_SAMPLES));

    assign out_load = (state_reg == S_ROOT) && stat.done && (!m_valid_reg || m_ready);

    // Sequence capture, accumulate and wait for the root
    always_comb begin
        state_next    = state_reg;
        mag_next      = mag_reg;
        last_next     = last_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        peak_next     = peak_reg;
        rms_out_next  = rms_out_reg;
        peak_out_next = peak_out_reg;
        ctrl.start    = 1'b0;
        ctrl.ack      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    mag_next   = mag_in;
                    last_next  = s_last;
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                sum_next   = sum_acc;
                count_next = count_acc;
                peak_next  = peak_acc;
                if (close) begin
                    // Hand the totals to the root unit and clear the running sum
                    ctrl.start = 1'b1;
                    sum_next   = '0;
                    count_next = '0;
                    state_next = S_ROOT;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_ROOT: begin
                if (out_load) begin
                    rms_out_next  = root;
                    peak_out_next = peak_reg;
                    peak_next     = '0;
                    ctrl.ack      = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result word until the receiver takes it
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            sum_reg     <= '0;
            count_reg   <= '0;
            peak_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            peak_reg    <= peak_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg      <= mag_next;
        last_reg     <= last_next;
        rms_out_reg  <= rms_out_next;
        peak_out_reg <= peak_out_next;
    end

    crpm_mean_root #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_mean_root (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .sum_in   (sum_acc),
        .count_in (count_acc),
        .stat     (stat),
        .root_out (root)
    );

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_rms_level  = rms_out_reg;
    assign m_peak_level = peak_out_reg;

    // Checks on the sequencing between accumulator, root unit and output
    `CRPM_ASSERT_HOLDS(a_idle_unit_quiet, aclk, aresetn, (state_reg == S_IDLE), !stat.busy)
    `CRPM_ASSERT_NEXT(a_start_sets_busy, aclk, aresetn, ctrl.start, stat.busy)
    `CRPM_ASSERT_NEXT(a_load_shows_word, aclk, aresetn, out_load, m_valid_reg)
    `CRPM_ASSERT_HOLDS(a_count_below_max, aclk, aresetn, 1'b1, count_reg < CNT_W'(MAX_CHUNK_SAMPLES))
    `CRPM_ASSERT_HOLDS(a_rms_within_peak, aclk, aresetn, m_valid_reg, rms_out_reg <= peak_out_reg)

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import crpm_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int CHUNK_LIMIT    = MAX_CHUNK_SAMPLES_DEF;
    localparam int RANDOM_ITEMS   = 1200;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 4000;

    // One sample word waiting to be offered, with the pacing that goes with it
    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        int unsigned                tx_idle;
        int unsigned                rx_idle;
        bit                         drain_first;
        bit                         hold_rx;
    } sample_word_t;

    // One predicted level word
    typedef struct {
        logic [LEVEL_W-1:0] rms;
        logic [LEVEL_W-1:0] peak;
    } level_word_t;

    logic                       aclk         = 1'b0;
    logic                       aresetn      = 1'b0;
    logic                       s_valid      = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample     = '0;
    logic                       s_last       = 1'b0;
    logic                       m_valid;
    logic                       m_ready      = 1'b0;
    logic [LEVEL_W-1:0]         m_rms_level;
    logic [LEVEL_W-1:0]         m_peak_level;

    sample_word_t sample_pending_q[$];
    level_word_t  level_expect_q[$];

    // Running chunk state of the predictor
    logic [42:0]        acc_square_sum = '0;
    logic [12:0]        acc_count      = '0;
    logic [LEVEL_W-1:0] acc_peak       = '0;

    // Pacing shared between the stimulus builder, driver and monitor
    int unsigned cur_tx_idle   = 10;
    int unsigned cur_rx_idle   = 77;
    bit          next_drain    = 1'b0;
    bit          next_hold     = 1'b0;
    int unsigned rx_idle_pct   = 77;
    int unsigned hold_requests = 0;
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;
    int unsigned stall_cycles  = 0;
    int unsigned fail_count    = 0;

    chunk_rms_peak_meter_core #(
        .MAX_CHUNK_SAMPLES(CHUNK_LIMIT)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rms_level (m_rms_level),
        .m_peak_level(m_peak_level)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Floor square root, one result bit at a time from the top
    function automatic logic [31:0] floor_root(input logic [63:0] radicand);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int b = 16; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= radicand) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Fold one accepted sample into the chunk; close the chunk on last or full length
    function automatic void meter_predict(input logic signed [SAMPLE_W-1:0] sample,
                                          input logic last);
        logic [LEVEL_W-1:0] mag;
        logic [42:0]        mean;
        level_word_t        word;
        mag = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
        acc_square_sum = acc_square_sum + 43'(mag) * 43'(mag);
        acc_count      = acc_count + 1'b1;
        if (mag > acc_peak) begin
            acc_peak = mag;
        end
        if (last || acc_count >= 13'(CHUNK_LIMIT)) begin
            mean      = acc_square_sum / 43'(acc_count);
            word.rms  = LEVEL_W'(floor_root(64'(mean)));
            word.peak = acc_peak;
            level_expect_q.push_back(word);
            acc_square_sum = '0;
            acc_count      = '0;
            acc_peak       = '0;
        end
    endfunction

    task automatic push_item(input logic signed [SAMPLE_W-1:0] sample, input logic last);
        sample_word_t word;
        word.sample      = sample;
        word.last        = last;
        word.tx_idle     = cur_tx_idle;
        word.rx_idle     = cur_rx_idle;
        word.drain_first = next_drain;
        word.hold_rx     = next_hold;
        next_drain       = 1'b0;
        next_hold        = 1'b0;
        sample_pending_q.push_back(word);
    endtask

    // Mix of extremes, small values near zero and full-range noise
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10) begin
            return 16'sh8000;
        end else if (roll < 20) begin
            return 16'sh7fff;
        end else if (roll < 40) begin
            return SAMPLE_W'(int'($urandom_range(128)) - 64);
        end
        return SAMPLE_W'($urandom);
    endfunction

    task automatic push_chunk(input int len);
        for (int i = 0; i < len; i++) begin
            push_item(pick_sample(), i == len - 1);
        end
    endtask

    // Driver: hold the word until accepted, then pace the next one
    always @(posedge aclk) begin
        sample_word_t word;
        logic         offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            offer = s_valid && !s_ready;
            if (s_valid && s_ready) begin
                meter_predict(s_sample, s_last);
            end
            if (!offer && sample_pending_q.size() > 0) begin
                word = sample_pending_q[0];
                if ((!word.drain_first || level_expect_q.size() == 0) &&
                    $urandom_range(99) >= word.tx_idle) begin
                    word = sample_pending_q.pop_front();
                    s_sample    <= word.sample;
                    s_last      <= word.last;
                    rx_idle_pct <= word.rx_idle;
                    if (word.hold_rx) begin
                        hold_requests <= hold_requests + 1;
                    end
                    offer = 1'b1;
                end
            end
            s_valid <= offer;
        end
    end

    // Monitor: check each level word against the oldest prediction, pace m_ready
    always @(posedge aclk) begin
        level_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (level_expect_q.size() == 0) begin
                    $display("%0t: unexpected level word rms %0d peak %0d",
                             $time, m_rms_level, m_peak_level);
                    fail_count++;
                end else begin
                    want = level_expect_q.pop_front();
                    if (m_rms_level !== want.rms) begin
                        $display("%0t: rms_level expected %0d actual %0d",
                                 $time, want.rms, m_rms_level);
                        fail_count++;
                    end
                    if (m_peak_level !== want.peak) begin
                        $display("%0t: peak_level expected %0d actual %0d",
                                 $time, want.peak, m_peak_level);
                        fail_count++;
                    end
                end
            end
            // Hold off for a long stretch on request, else idle at random
            if (hold_seen != hold_requests) begin
                hold_seen <= hold_requests;
                hold_left <= LONG_HOLD;
                m_ready   <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int unsigned random_items;
        int          len;
        bit          phase_b_done;
        bit          phase_c_done;
        bit          hold_done;

        // Directed: chunks of one at the extremes and near zero
        push_item(16'sd0, 1'b1);
        push_item(16'sh8000, 1'b1);
        push_item(16'sh7fff, 1'b1);
        push_item(-16'sd1, 1'b1);
        push_item(16'sd1, 1'b1);
        // Short chunks mixing signs and both extremes
        push_item(16'sd1, 1'b0);
        push_item(-16'sd1, 1'b0);
        push_item(16'sd2, 1'b0);
        push_item(-16'sd2, 1'b1);
        push_item(16'sh7fff, 1'b0);
        push_item(16'sh8000, 1'b0);
        push_item(16'sd0, 1'b1);
        push_item(16'sh5555, 1'b0);
        push_item(16'shaaaa, 1'b1);
        // Full-length chunk of the largest magnitude with no last mark,
        // then a lone sample that forms a chunk of one
        for (int i = 0; i < CHUNK_LIMIT; i++) begin
            push_item(16'sh8000, 1'b0);
        end
        push_item(16'sd5, 1'b1);

        // Random chunks, mostly short, through three pacing phases
        random_items = 0;
        phase_b_done = 1'b0;
        phase_c_done = 1'b0;
        hold_done    = 1'b0;
        while (random_items < RANDOM_ITEMS) begin
            if (!phase_b_done && random_items >= RANDOM_ITEMS / 3) begin
                cur_tx_idle  = 77;
                cur_rx_idle  = 10;
                next_drain   = 1'b1;
                phase_b_done = 1'b1;
            end
            if (!phase_c_done && random_items >= 2 * RANDOM_ITEMS / 3) begin
                cur_tx_idle  = 0;
                cur_rx_idle  = 0;
                next_drain   = 1'b1;
                phase_c_done = 1'b1;
            end
            if (phase_c_done && !hold_done && random_items >= 3 * RANDOM_ITEMS / 4) begin
                next_hold = 1'b1;
                hold_done = 1'b1;
            end
            len = ($urandom_range(99) < 85) ? $urandom_range(12, 1) : $urandom_range(100, 13);
            push_chunk(len);
            random_items += len;
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain: all words offered, then all level words back, then settle
        while (sample_pending_q.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        while (level_expect_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && level_expect_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
